// File: sv/ptce_pkg.sv
// Shared types and constants for the PNG tEXt chunk extractor.
package ptce_pkg;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4
	} phase_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] text_char;
		logic       char_valid;
		logic       text_last;
	} res_t;

	// Write side of the result queue.
	typedef struct packed {
		logic valid;
		res_t res;
	} q_wr_t;

	localparam int SIGNATURE_BYTES_DEF = 8;
	localparam int LEN_BYTES           = 4;
	localparam int TYPE_BYTES          = 4;
	localparam int CRC_BYTES           = 4;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [7:0] NUL_BYTE = 8'h00;

	// "tEXt"
	localparam logic [7:0] TEXT_TAG [TYPE_BYTES] = '{8'h74, 8'h45, 8'h58, 8'h74};

endpackage

// File: sv/png_text_chunk_extractor_core.sv
// Top level of the PNG tEXt chunk extractor.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   input    | push / full        | data_byte, first_byte
//   result   | empty / pop        | text_char, char_valid, text_last
//
// One byte is accepted per cycle while !full; each accepted byte steps the parser.
// A result beat is queued as its byte is accepted, then moves to the output register.
// full rises only when the four-entry result queue is full behind a stalled output.
// After reset the parser waits for the signature, if any, and the result side is empty.
module png_text_chunk_extractor_core
	import ptce_pkg::*;
#(
	parameter int SIGNATURE_BYTES = SIGNATURE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] text_char,
	output logic       char_valid,
	output logic       text_last
);

	q_wr_t wr;
	logic  rd_en;
	logic  rd_valid;
	res_t  rd_data;

	ptce_front #(
		.SIGNATURE_BYTES(SIGNATURE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !full),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.wr        (wr)
	);

	ptce_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.full    (full),
		.rd_en   (rd_en),
		.rd_valid(rd_valid),
		.rd_data (rd_data)
	);

	ptce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data),
		.rd_en     (rd_en),
		.pop       (pop),
		.empty     (empty),
		.text_char (text_char),
		.char_valid(char_valid),
		.text_last (text_last)
	);

endmodule

// File: sv/ptce_front.sv
// Front end: chunk parser that classifies each byte and produces result beats.
module ptce_front
	import ptce_pkg::*;
#(
	parameter int SIGNATURE_BYTES = SIGNATURE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output q_wr_t      wr
);

	localparam phase_t     PHASE_RST = (SIGNATURE_BYTES > 0) ? PH_SIG : PH_LEN;
	localparam logic [3:0] SIG_CNT   = 4'(SIGNATURE_BYTES);
	localparam logic [3:0] LEN_CNT   = 4'(LEN_BYTES);
	localparam logic [3:0] TYPE_CNT  = 4'(TYPE_BYTES);
	localparam logic [3:0] CRC_CNT   = 4'(CRC_BYTES);

	phase_t      phase_q, phase_d, eff_phase;
	logic [3:0]  fc_q, fc_d, eff_fc, fc_inc;
	logic [31:0] len_q, len_d, eff_len;
	logic [31:0] left_q, left_d, eff_left, left_dec;
	logic        tm_q, tm_d, eff_tm;
	logic        sep_q, sep_d, eff_sep;
	logic        last;

	// Restart from reset values when a new file begins.
	always_comb begin
		if (first_byte) begin
			eff_phase = PHASE_RST;
			eff_fc    = '0;
			eff_len   = '0;
			eff_left  = '0;
			eff_tm    = 1'b1;
			eff_sep   = 1'b0;
		end else begin
			eff_phase = phase_q;
			eff_fc    = fc_q;
			eff_len   = len_q;
			eff_left  = left_q;
			eff_tm    = tm_q;
			eff_sep   = sep_q;
		end
	end

	assign fc_inc   = eff_fc + 4'd1;
	assign left_dec = eff_left - 32'd1;
	assign last     = (left_dec == '0);

	// Next state of the parser.
	always_comb begin
		phase_d = eff_phase;
		fc_d    = eff_fc;
		len_d   = eff_len;
		left_d  = eff_left;
		tm_d    = eff_tm;
		sep_d   = eff_sep;
		unique case (eff_phase)
			PH_SIG: begin
				fc_d = fc_inc;
				if (fc_inc >= SIG_CNT || fc_inc == '0) begin
					fc_d    = '0;
					phase_d = PH_LEN;
				end
			end
			PH_TYPE: begin
				if (data_byte != TEXT_TAG[eff_fc[1:0]])
					tm_d = 1'b0;
				fc_d = fc_inc;
				if (fc_inc >= TYPE_CNT) begin
					fc_d    = '0;
					left_d  = eff_len;
					sep_d   = 1'b0;
					phase_d = (eff_len != '0) ? PH_DATA : PH_CRC;
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				if (eff_tm && !eff_sep && data_byte == NUL_BYTE)
					sep_d = 1'b1;
				if (last)
					phase_d = PH_CRC;
			end
			PH_CRC: begin
				fc_d = fc_inc;
				if (fc_inc >= CRC_CNT) begin
					fc_d    = '0;
					len_d   = '0;
					phase_d = PH_LEN;
				end
			end
			default: begin
				// Length gathering, also for unused codes.
				phase_d = PH_LEN;
				len_d   = {eff_len[23:0], data_byte};
				fc_d    = fc_inc;
				if (fc_inc >= LEN_CNT) begin
					fc_d    = '0;
					tm_d    = 1'b1;
					phase_d = PH_TYPE;
				end
			end
		endcase
	end

	// Emit text after the separator, or a bare end mark if the separator closes the chunk.
	always_comb begin
		wr.valid          = accept && eff_phase == PH_DATA && eff_tm &&
		                    (eff_sep || (data_byte == NUL_BYTE && last));
		wr.res.text_char  = eff_sep ? data_byte : NUL_BYTE;
		wr.res.char_valid = eff_sep;
		wr.res.text_last  = last;
	end

	// Advance state on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_RST;
			fc_q    <= '0;
			len_q   <= '0;
			left_q  <= '0;
			tm_q    <= 1'b1;
			sep_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			fc_q    <= fc_d;
			len_q   <= len_d;
			left_q  <= left_d;
			tm_q    <= tm_d;
			sep_q   <= sep_d;
		end
	end

endmodule

// File: sv/ptce_queue.sv
// Short result queue between the parser and the output stage.
module ptce_queue
	import ptce_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	output logic  full,
	input  logic  rd_en,
	output logic  rd_valid,
	output res_t  rd_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	res_t          mem_q [QUEUE_DEPTH];
	logic [AW:0]   wptr_q, rptr_q;

	assign full     = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign rd_valid = (wptr_q != rptr_q);
	assign rd_data  = mem_q[rptr_q[AW-1:0]];

	// Store beats.
	always_ff @(posedge clk) begin
		if (wr.valid && !full)
			mem_q[wptr_q[AW-1:0]] <= wr.res;
	end

	// Advance pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr.valid && !full)
				wptr_q <= wptr_q + (AW+1)'(1);
			if (rd_en && rd_valid)
				rptr_q <= rptr_q + (AW+1)'(1);
		end
	end

endmodule

// File: sv/ptce_back.sv
// Back end: output register that presents the oldest result beat.
module ptce_back
	import ptce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_valid,
	input  res_t       rd_data,
	output logic       rd_en,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] text_char,
	output logic       char_valid,
	output logic       text_last
);

	logic out_valid_q;
	res_t out_q;

	// Refill when the register is free or being drained.
	assign rd_en = rd_valid && (!out_valid_q || pop);

	assign empty      = !out_valid_q;
	assign text_char  = out_q.text_char;
	assign char_valid = out_q.char_valid;
	assign text_last  = out_q.text_last;

	// Hold the payload until taken.
	always_ff @(posedge clk) begin
		if (rd_en)
			out_q <= rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_en) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/ptce_checker.sv
// Port-level checks for the PNG tEXt chunk extractor, bound to the top level.
module ptce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] text_char,
	input logic       char_valid,
	input logic       text_last
);

	// A bare end mark only closes a chunk.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !char_valid |-> text_last)
	else $error("bare end mark without last");

	// A stalled beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(text_char) && $stable(char_valid) &&
		$stable(text_last))
	else $error("stalled result changed");

	// The queue cannot fill while the output register is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
	else $error("full with empty output");

	// No result appears without accepted input.
	assert property (@(posedge clk) disable iff (!arst_n)
		empty && $past(empty) && !(push && !full) && !$past(push && !full) |=> empty)
	else $error("result without input");

endmodule

bind png_text_chunk_extractor_core ptce_checker u_ptce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.text_char (text_char),
	.char_valid(char_valid),
	.text_last (text_last)
);
